### rtl/temporal_delta_paeth_filter_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the temporal delta Paeth filter checkers.
// ----------------------------------------------------------------------------
`ifndef TEMPORAL_DELTA_PAETH_FILTER_TOP_MACROS_SVH
`define TEMPORAL_DELTA_PAETH_FILTER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TDPF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TDPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tdpf_pkg.sv
// ----------------------------------------------------------------------------
// tdpf_pkg
// Types and constants of the temporal delta Paeth filter.
// ----------------------------------------------------------------------------
package tdpf_pkg;

  localparam int PIX_W  = 8;
  localparam int IDX_W  = 20;
  localparam int SIZE_W = 11;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_PREDICT_ENABLE = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] cur_red;
    logic [PIX_W-1:0] cur_green;
    logic [PIX_W-1:0] cur_blue;
    logic [PIX_W-1:0] cur_alpha;
    logic [PIX_W-1:0] prev_red;
    logic [PIX_W-1:0] prev_green;
    logic [PIX_W-1:0] prev_blue;
    logic [PIX_W-1:0] prev_alpha;
  } in_data_t;

  typedef struct packed {
    logic [PIX_W-1:0] res_red;
    logic [PIX_W-1:0] res_green;
    logic [PIX_W-1:0] res_blue;
    logic [PIX_W-1:0] res_alpha;
    logic [IDX_W-1:0] pixel_index;
    logic             frame_last;
  } out_data_t;

  // Four channels packed with red in the low byte.
  typedef logic [4*PIX_W-1:0] pixel_t;

endpackage

### rtl/tdpf_ram.sv
// ----------------------------------------------------------------------------
// tdpf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tdpf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // A read and a write to the same entry in one cycle return the old data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/tdpf_paeth.sv
// ----------------------------------------------------------------------------
// tdpf_paeth
// Paeth predictor for one 8-bit channel.
// ----------------------------------------------------------------------------
module tdpf_paeth (
  input  logic [tdpf_pkg::PIX_W-1:0] a,
  input  logic [tdpf_pkg::PIX_W-1:0] b,
  input  logic [tdpf_pkg::PIX_W-1:0] c,
  output logic [tdpf_pkg::PIX_W-1:0] pred
);

  localparam int SW = tdpf_pkg::PIX_W + 3;
  localparam int MW = tdpf_pkg::PIX_W + 2;

  logic signed [SW-1:0] p;
  logic signed [SW-1:0] da;
  logic signed [SW-1:0] db;
  logic signed [SW-1:0] dc;
  logic [MW-1:0]        pa;
  logic [MW-1:0]        pb;
  logic [MW-1:0]        pc;

  always_comb begin
    p  = $signed(SW'(a)) + $signed(SW'(b)) - $signed(SW'(c));
    da = p - $signed(SW'(a));
    db = p - $signed(SW'(b));
    dc = p - $signed(SW'(c));
    pa = (da < 0) ? MW'(-da) : MW'(da);
    pb = (db < 0) ? MW'(-db) : MW'(db);
    pc = (dc < 0) ? MW'(-dc) : MW'(dc);
    if (pa <= pb && pa <= pc) begin
      pred = a;
    end else if (pb <= pc) begin
      pred = b;
    end else begin
      pred = c;
    end
  end

endmodule

### rtl/temporal_delta_paeth_filter_top.sv
// ----------------------------------------------------------------------------
// temporal_delta_paeth_filter_top
// Temporal difference of RGBA pixels with optional Paeth spatial prediction.
//
//   channel  direction  payload      handshake
//   in_      input      in_data_t    in_valid / in_stall
//   out_     output     out_data_t   out_valid / out_stall
//   cfg_     input      registers    APB write, pready tied high
//
// One pixel is taken per clock unless the input is stalled; a result passes
// through the middle stage and the output register. The row store is one RAM
// with a registered read; the read of the upper pixel and the write of the
// current pixel share the request cycle. Reset clears the counters, the edge
// pixels and the registers; the row store is not cleared. A stalled output holds
// the result and stalls the input only when the middle stage is full as well.
// ----------------------------------------------------------------------------
module temporal_delta_paeth_filter_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tdpf_pkg::in_data_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tdpf_pkg::out_data_t           out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tdpf_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [tdpf_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [tdpf_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int PW  = tdpf_pkg::PIX_W;
  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int CXW = (CW + 1 > WW) ? CW + 1 : WW;
  localparam int RXW = (RW + 1 > HW) ? RW + 1 : HW;
  localparam int MW  = RW + WW;
  localparam int SW  = ((MW > CW) ? MW : CW) + 1;

  // Configuration registers.
  logic [tdpf_pkg::SIZE_W-1:0] frame_width_r;
  logic [tdpf_pkg::SIZE_W-1:0] frame_height_r;
  logic                        predict_enable_r;
  logic                        cfg_wr;
  tdpf_pkg::reg_idx_t          cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = tdpf_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= tdpf_pkg::SIZE_W'(256);
      frame_height_r   <= tdpf_pkg::SIZE_W'(256);
      predict_enable_r <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        tdpf_pkg::REG_FRAME_WIDTH:    frame_width_r    <= cfg_pwdata[tdpf_pkg::SIZE_W-1:0];
        tdpf_pkg::REG_FRAME_HEIGHT:   frame_height_r   <= cfg_pwdata[tdpf_pkg::SIZE_W-1:0];
        tdpf_pkg::REG_PREDICT_ENABLE: predict_enable_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      tdpf_pkg::REG_FRAME_WIDTH:    cfg_prdata = tdpf_pkg::CFG_DW'(frame_width_r);
      tdpf_pkg::REG_FRAME_HEIGHT:   cfg_prdata = tdpf_pkg::CFG_DW'(frame_height_r);
      tdpf_pkg::REG_PREDICT_ENABLE: cfg_prdata = tdpf_pkg::CFG_DW'(predict_enable_r);
      default:                      cfg_prdata = '0;
    endcase
  end

  // Effective frame size: zero acts as one, oversize acts as the maximum.
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(frame_height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height_r);
    end
  end

  // Pipeline handshake.
  logic s1_valid_r;
  logic out_valid_r;
  logic out_ready;
  logic s1_ready;
  logic accept;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_ready  = !s1_valid_r || out_ready;
  assign in_stall  = !s1_ready;
  assign accept    = in_valid && s1_ready;

  // Raster counters and the request-side view of the current pixel.
  logic [CW-1:0]     col_r;
  logic [RW-1:0]     row_r;
  logic [CW-1:0]     col_nxt;
  logic [RW-1:0]     row_nxt;
  logic              col_wrap;
  logic              row_wrap;
  logic [MW-1:0]     row_base;
  logic [SW-1:0]     index_sum;
  tdpf_pkg::pixel_t  cur_pix;
  tdpf_pkg::pixel_t  left_r;

  assign cur_pix = {in_data.cur_alpha, in_data.cur_blue, in_data.cur_green, in_data.cur_red};

  always_comb begin
    col_wrap  = (CXW'(col_r) + CXW'(1)) >= CXW'(w_eff);
    row_wrap  = (RXW'(row_r) + RXW'(1)) >= RXW'(h_eff);
    col_nxt   = col_wrap ? '0 : col_r + CW'(1);
    row_nxt   = col_wrap ? (row_wrap ? '0 : row_r + RW'(1)) : row_r;
    row_base  = MW'(row_r) * MW'(w_eff);
    index_sum = SW'(row_base) + SW'(col_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      left_r <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      left_r <= cur_pix;
    end
  end

  // Row store: the upper pixel is read and replaced in the request cycle.
  tdpf_pkg::pixel_t up_raw;

  tdpf_ram #(
    .WIDTH ($bits(tdpf_pkg::pixel_t)),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk   (clk),
    .we    (accept),
    .waddr (col_r),
    .wdata (cur_pix),
    .re    (accept),
    .raddr (col_r),
    .rdata (up_raw)
  );

  // Middle stage: holds the request while the upper pixel is read.
  tdpf_pkg::pixel_t              s1_cur_r;
  tdpf_pkg::pixel_t              s1_prev_r;
  tdpf_pkg::pixel_t              s1_left_r;
  logic                          s1_has_up_r;
  logic                          s1_has_ul_r;
  logic                          s1_predict_r;
  logic [tdpf_pkg::IDX_W-1:0]    s1_index_r;
  logic                          s1_last_r;
  tdpf_pkg::pixel_t              ul_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (out_ready) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur_r     <= cur_pix;
      s1_prev_r    <= {in_data.prev_alpha, in_data.prev_blue,
                       in_data.prev_green, in_data.prev_red};
      s1_left_r    <= (col_r != '0) ? left_r : '0;
      s1_has_up_r  <= (row_r != '0);
      s1_has_ul_r  <= (row_r != '0) && (col_r != '0);
      s1_predict_r <= predict_enable_r;
      s1_index_r   <= tdpf_pkg::IDX_W'(index_sum);
      s1_last_r    <= col_wrap && row_wrap;
    end
  end

  // The upper-left pixel is the upper pixel of the request before this one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ul_r <= '0;
    end else if (s1_valid_r && out_ready) begin
      ul_r <= up_raw;
    end
  end

  tdpf_pkg::pixel_t up_pix;
  tdpf_pkg::pixel_t ul_pix;
  tdpf_pkg::pixel_t pred_pix;
  tdpf_pkg::pixel_t res_pix;

  assign up_pix = s1_has_up_r ? up_raw : '0;
  assign ul_pix = s1_has_ul_r ? ul_r : '0;

  for (genvar g = 0; g < 4; g++) begin : g_chan
    tdpf_paeth u_paeth (
      .a    (s1_left_r[g*PW +: PW]),
      .b    (up_pix[g*PW +: PW]),
      .c    (ul_pix[g*PW +: PW]),
      .pred (pred_pix[g*PW +: PW])
    );
    assign res_pix[g*PW +: PW] = s1_cur_r[g*PW +: PW] - s1_prev_r[g*PW +: PW]
                               - (s1_predict_r ? pred_pix[g*PW +: PW] : '0);
  end

  // Output register.
  tdpf_pkg::out_data_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid_r) begin
      out_data_r.res_red     <= res_pix[0*PW +: PW];
      out_data_r.res_green   <= res_pix[1*PW +: PW];
      out_data_r.res_blue    <= res_pix[2*PW +: PW];
      out_data_r.res_alpha   <= res_pix[3*PW +: PW];
      out_data_r.pixel_index <= s1_index_r;
      out_data_r.frame_last  <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/tdpf_checker.sv
// ----------------------------------------------------------------------------
// tdpf_checker
// Port-level checks of the temporal delta Paeth filter, bound to its top level.
// ----------------------------------------------------------------------------
`include "temporal_delta_paeth_filter_top_macros.svh"

module tdpf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input tdpf_pkg::out_data_t out_data
);

  logic       in_take;
  logic       out_take;
  logic [1:0] pending_r;
  logic       after_last_r;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // Requests taken but not yet delivered; the block holds at most two.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_take && !out_take) begin
      pending_r <= pending_r + 2'd1;
    end else if (out_take && !in_take) begin
      pending_r <= pending_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      after_last_r <= 1'b1;
    end else if (out_take) begin
      after_last_r <= out_data.frame_last;
    end
  end

  `TDPF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `TDPF_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled while output is free")
  `TDPF_ASSERT_NOW(a_no_invent, clk, rst_n, out_valid, pending_r != 2'd0 && pending_r != 2'd3, "result without a pending request")
  `TDPF_ASSERT_NOW(a_frame_start, clk, rst_n, out_take && after_last_r, out_data.pixel_index == '0, "frame does not start at pixel zero")

endmodule

bind temporal_delta_paeth_filter_top tdpf_checker u_tdpf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
